// File: hdl/dipr_pkg.sv
// Shared definitions for the dual incremental PI controller with setpoint ramp.
// Holds the configuration register indexes, reset values and the config struct.
// No dependencies.
package dipr_pkg;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 16;

	localparam logic [CfgIndexWidth-1:0] REG_SPEED_GOAL  = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_RAMP_STEP   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_LAUNCH_PWM  = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_PROP_GAIN   = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_INTEG_GAIN  = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_PWM_LIMIT   = 3'd5;

	localparam logic signed [15:0] RST_SPEED_GOAL  = 16'sd300;
	localparam logic [9:0]         RST_RAMP_STEP   = 10'd8;
	localparam logic [15:0]        RST_LAUNCH_PWM  = 16'd2000;
	localparam logic [7:0]         RST_PROP_GAIN   = 8'd10;
	localparam logic [7:0]         RST_INTEG_GAIN  = 8'd1;
	localparam logic [15:0]        RST_PWM_LIMIT   = 16'd7199;

	typedef struct packed {
		logic signed [15:0] speed_goal;
		logic [9:0]         ramp_step;
		logic [15:0]        launch_pwm;
		logic [7:0]         prop_gain;
		logic [7:0]         integ_gain;
		logic [15:0]        pwm_limit;
	} cfg_t;

endpackage

// File: hdl/dipr_lane.sv
// One wheel lane: incremental PI update with clamp, holding drive and last error.
// Depends on dipr_pkg for the configuration struct.
module dipr_lane import dipr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               restart,
	input  cfg_t               cfg,
	input  logic signed [15:0] encoder,
	input  logic signed [15:0] target,
	output logic [15:0]        drive
);

	logic [15:0]        drive_q;
	logic signed [16:0] prev_err_q;
	logic signed [16:0] err;
	logic signed [17:0] diff;
	logic signed [26:0] prop;
	logic signed [25:0] integ;
	logic signed [27:0] acc;
	logic [15:0]        drive_nxt;

	always_comb begin
		err   = {target[15], target} - {encoder[15], encoder};
		diff  = {err[16], err} - {prev_err_q[16], prev_err_q};
		prop  = $signed({1'b0, cfg.prop_gain}) * diff;
		integ = $signed({1'b0, cfg.integ_gain}) * err;
		acc   = $signed({12'd0, drive_q}) + {prop[26], prop} + {{2{integ[25]}}, integ};
		if (acc < 28'sd0) begin
			drive_nxt = 16'd0;
		end else if (acc > $signed({12'd0, cfg.pwm_limit})) begin
			drive_nxt = cfg.pwm_limit;
		end else begin
			drive_nxt = acc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q    <= '0;
			prev_err_q <= '0;
		end else if (fire) begin
			if (restart) begin
				drive_q    <= cfg.launch_pwm;
				prev_err_q <= '0;
			end else begin
				drive_q    <= drive_nxt;
				prev_err_q <= err;
			end
		end
	end

	assign drive = drive_q;

endmodule

// File: hdl/dipr_ramp.sv
// Setpoint ramp: moves the ramp value toward the target speed without overshoot.
// Depends on dipr_pkg for the configuration struct.
module dipr_ramp import dipr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               restart,
	input  cfg_t               cfg,
	output logic signed [15:0] ramp
);

	logic signed [15:0] ramp_q;
	logic signed [17:0] cur;
	logic signed [17:0] tgt;
	logic signed [17:0] up;
	logic signed [17:0] down;
	logic signed [15:0] ramp_nxt;

	always_comb begin
		cur  = {{2{ramp_q[15]}}, ramp_q};
		tgt  = {{2{cfg.speed_goal[15]}}, cfg.speed_goal};
		up   = cur + $signed({8'd0, cfg.ramp_step});
		down = cur - $signed({8'd0, cfg.ramp_step});
		if (cur < tgt) begin
			ramp_nxt = (up > tgt) ? cfg.speed_goal : up[15:0];
		end else if (cur > tgt) begin
			ramp_nxt = (down < tgt) ? cfg.speed_goal : down[15:0];
		end else begin
			ramp_nxt = ramp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= '0;
		end else if (fire) begin
			ramp_q <= restart ? 16'sd0 : ramp_nxt;
		end
	end

	assign ramp = ramp_q;

endmodule

// File: hdl/dual_incremental_pi_with_ramp.sv
// Top level of the dual incremental PI controller with setpoint ramp.
// Each accepted input beat yields its output beat in the following cycle; both lanes
// and the ramp update in the same cycle; one beat per cycle while output is not stalled.
// Reset (arst_n low) clears drives, stored errors, ramp and output valid, and loads
// the configuration registers with their default values.
// Depends on dipr_pkg, dipr_lane and dipr_ramp.
module dual_incremental_pi_with_ramp import dipr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// encoder_left, encoder_right, target_left, target_right
	input  logic [63:0]              s_axis_tdata,
	// restart
	input  logic                     s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// pwm_left, pwm_right, ramp_target
	output logic [47:0]              m_axis_tdata
);

	cfg_t               cfg_q;
	logic               out_valid_q;
	logic               fire;
	logic [15:0]        pwm_left;
	logic [15:0]        pwm_right;
	logic signed [15:0] ramp_target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_goal <= RST_SPEED_GOAL;
			cfg_q.ramp_step  <= RST_RAMP_STEP;
			cfg_q.launch_pwm <= RST_LAUNCH_PWM;
			cfg_q.prop_gain  <= RST_PROP_GAIN;
			cfg_q.integ_gain <= RST_INTEG_GAIN;
			cfg_q.pwm_limit  <= RST_PWM_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_GOAL:  cfg_q.speed_goal <= cfg_data;
				REG_RAMP_STEP:   cfg_q.ramp_step  <= cfg_data[9:0];
				REG_LAUNCH_PWM:  cfg_q.launch_pwm <= cfg_data;
				REG_PROP_GAIN:   cfg_q.prop_gain  <= cfg_data[7:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain <= cfg_data[7:0];
				REG_PWM_LIMIT:   cfg_q.pwm_limit  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign fire          = s_axis_tvalid && s_axis_tready;

	dipr_lane u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.restart (s_axis_tuser),
		.cfg     (cfg_q),
		.encoder (s_axis_tdata[15:0]),
		.target  (s_axis_tdata[47:32]),
		.drive   (pwm_left)
	);

	dipr_lane u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.restart (s_axis_tuser),
		.cfg     (cfg_q),
		.encoder (s_axis_tdata[31:16]),
		.target  (s_axis_tdata[63:48]),
		.drive   (pwm_right)
	);

	dipr_ramp u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.restart (s_axis_tuser),
		.cfg     (cfg_q),
		.ramp    (ramp_target)
	);

	// The lane state registers hold the result of the last beat until the next one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {ramp_target, pwm_right, pwm_left};

	a_restart_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire && s_axis_tuser |=> ramp_target == 16'sd0
			&& pwm_left == $past(cfg_q.launch_pwm) && pwm_right == $past(cfg_q.launch_pwm))
		else $error("restart beat did not load start value");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !s_axis_tuser |=> pwm_left <= $past(cfg_q.pwm_limit)
			&& pwm_right <= $past(cfg_q.pwm_limit))
		else $error("drive exceeds limit after control step");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output beat is stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(m_axis_tdata))
		else $error("result changed without an accepted beat");

endmodule
